// ===== design/aik_pkg.sv =====
// ----------------------------------------------------------------------------
// aik_pkg: shared types and constants of the arm inverse kinematics core
// Widths, CORDIC arctangent table, angle limits and register indexes.
// ----------------------------------------------------------------------------
package aik_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN = 24;

	localparam int CFG_W = 15;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;
	localparam logic [CFG_W-1:0] UPPER_RESET = 15'd5120;
	localparam logic [CFG_W-1:0] LOWER_RESET = 15'd3840;

	// CORDIC operand, working vector and angle accumulator widths.
	localparam int OPW = 34;
	localparam int XW = 46;
	localparam int ACCW = 32;
	localparam int ANGW = 16;
	// Normalization brings the larger magnitude up to bit NORM_W-1.
	localparam int NORM_W = 41;
	localparam int NORM_STEPS = 6;
	localparam int ROUND_SHIFT = 16;

	// Integer square root radicand width and step count.
	localparam int SQW = 62;
	localparam int SQ_STEPS = SQW / 2;

	// Stages of the front end ahead of the square roots.
	localparam int FRONT_STAGES = 8;

	typedef logic signed [OPW-1:0] op_t;
	typedef logic signed [XW-1:0] vec_t;
	typedef logic signed [ACCW-1:0] fine_t;
	typedef logic signed [ANGW-1:0] ang_t;

	typedef struct packed {
		vec_t  x;
		vec_t  y;
		fine_t acc;
		logic  zero;
	} cordic_st_t;

	localparam fine_t DEG90_FINE = 32'sd377487360;
	localparam fine_t ROUND_HALF = 32'sd32768;

	// atan(2^-i) in degrees * 2^22.
	localparam fine_t ATAN_FINE [ATAN_LEN] = '{
		32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
		32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
		32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
		32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
		32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
		32'sd229, 32'sd115, 32'sd57, 32'sd29
	};

	localparam ang_t BASE_MAX = 16'sd11520;
	localparam ang_t BASE_MIN = -16'sd11520;
	localparam ang_t ELBOW_MAX = 16'sd11520;
	localparam logic signed [ANGW:0] SH_MAX = 17'sd5760;
	localparam logic signed [ANGW:0] SH_MIN = -17'sd17280;

endpackage

// ===== design/aik_target_if.sv =====
// ----------------------------------------------------------------------------
// aik_target_if: target point channel
// Valid/ready channel carrying one target point per beat.
// ----------------------------------------------------------------------------
interface aik_target_if;
	logic valid;
	logic ready;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic signed [15:0] target_z;

	modport source (output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink (input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

// ===== design/aik_joint_if.sv =====
// ----------------------------------------------------------------------------
// aik_joint_if: joint angle channel
// Valid/ready channel carrying one set of joint angles per beat.
// ----------------------------------------------------------------------------
interface aik_joint_if;
	logic valid;
	logic ready;
	logic signed [14:0] yaw_angle;
	logic signed [15:0] shoulder_angle;
	logic [13:0] elbow_angle;

	modport source (output valid, output yaw_angle, output shoulder_angle,
		output elbow_angle, input ready);
	modport sink (input valid, input yaw_angle, input shoulder_angle,
		input elbow_angle, output ready);
endinterface

// ===== design/aik_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// aik_sqrt_cell: one digit of the pipelined integer square root
// Tries one result bit and passes remainder and partial root on.
// ----------------------------------------------------------------------------
module aik_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [aik_pkg::SQW-1:0] v_in,
	input  logic [aik_pkg::SQW-1:0] res_in,
	output logic [aik_pkg::SQW-1:0] v_q,
	output logic [aik_pkg::SQW-1:0] res_q
);
	localparam logic [aik_pkg::SQW-1:0] BIT = aik_pkg::SQW'(1) << (aik_pkg::SQW - 2 - 2 * STEP);

	logic [aik_pkg::SQW-1:0] trial;

	assign trial = res_in + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_in >= trial) begin
				v_q   <= v_in - trial;
				res_q <= (res_in >> 1) + BIT;
			end else begin
				v_q   <= v_in;
				res_q <= res_in >> 1;
			end
		end
	end
endmodule

// ===== design/aik_sqrt.sv =====
// ----------------------------------------------------------------------------
// aik_sqrt: pipelined integer square root
// A row of digit cells, one result bit per stage, floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module aik_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [aik_pkg::SQW-1:0]   radicand,
	output logic [aik_pkg::SQW/2-1:0] root
);
	localparam int N = aik_pkg::SQ_STEPS;

	logic [aik_pkg::SQW-1:0] vv [N];
	logic [aik_pkg::SQW-1:0] rr [N];
	logic [aik_pkg::SQW-1:0] last_trial;

	assign vv[0] = radicand;
	assign rr[0] = '0;

	for (genvar k = 0; k < N - 1; k++) begin : g_cell
		aik_sqrt_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.en     (en),
			.v_in   (vv[k]),
			.res_in (rr[k]),
			.v_q    (vv[k+1]),
			.res_q  (rr[k+1])
		);
	end

	// The final digit only needs the root, not the remainder.
	assign last_trial = rr[N-1] + aik_pkg::SQW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (vv[N-1] >= last_trial) begin
				root <= (aik_pkg::SQW/2)'((rr[N-1] >> 1) + aik_pkg::SQW'(1));
			end else begin
				root <= (aik_pkg::SQW/2)'(rr[N-1] >> 1);
			end
		end
	end
endmodule

// ===== design/aik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aik_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-IDX) and books the angle.
// ----------------------------------------------------------------------------
module aik_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  aik_pkg::cordic_st_t d,
	output aik_pkg::cordic_st_t q
);
	aik_pkg::cordic_st_t nxt;
	aik_pkg::vec_t       dx;
	aik_pkg::vec_t       dy;

	always_comb begin
		nxt = d;
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		if (d.y > 0) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.acc = d.acc + aik_pkg::ATAN_FINE[IDX];
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.acc = d.acc - aik_pkg::ATAN_FINE[IDX];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ===== design/aik_cordic.sv =====
// ----------------------------------------------------------------------------
// aik_cordic: pipelined CORDIC arctangent
// Quadrant fold, normalizing shift stages, micro-rotation cells, rounding.
// Gives atan2(y, x) in degrees * 64.
// ----------------------------------------------------------------------------
module aik_cordic #(
	parameter int STAGES = aik_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  aik_pkg::op_t  y_in,
	input  aik_pkg::op_t  x_in,
	output aik_pkg::ang_t angle
);
	localparam int NS = aik_pkg::NORM_STEPS;
	localparam int NW = aik_pkg::NORM_W;

	aik_pkg::cordic_st_t pre;
	aik_pkg::vec_t       xe;
	aik_pkg::vec_t       ye;
	aik_pkg::vec_t       ax;
	aik_pkg::vec_t       ay;
	logic [NW-1:0]       m;

	aik_pkg::cordic_st_t nst [NS+1];
	logic [NW-1:0]       nm [NS];
	aik_pkg::cordic_st_t cst [STAGES+1];
	aik_pkg::fine_t      rounded;

	// Fold the left half plane by a quarter turn so the cells converge.
	always_comb begin
		xe = aik_pkg::XW'(x_in);
		ye = aik_pkg::XW'(y_in);
		pre.zero = (x_in == '0) && (y_in == '0);
		pre.x = xe;
		pre.y = ye;
		pre.acc = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				pre.x = ye;
				pre.y = -xe;
				pre.acc = aik_pkg::DEG90_FINE;
			end else begin
				pre.x = -ye;
				pre.y = xe;
				pre.acc = -aik_pkg::DEG90_FINE;
			end
		end
		ax = (pre.x < 0) ? -pre.x : pre.x;
		ay = (pre.y < 0) ? -pre.y : pre.y;
		m = NW'(ax | ay);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nst[0] <= pre;
			nm[0]  <= m;
		end
	end

	// Each stage shifts left by half the previous amount if the top bits allow.
	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = 1 << (NS - 1 - k);
		logic fits;

		assign fits = (nm[k][NW-1 -: SH] == '0);

		always_ff @(posedge clk) begin
			if (en) begin
				nst[k+1].x    <= fits ? (nst[k].x <<< SH) : nst[k].x;
				nst[k+1].y    <= fits ? (nst[k].y <<< SH) : nst[k].y;
				nst[k+1].acc  <= nst[k].acc;
				nst[k+1].zero <= nst[k].zero;
			end
		end

		if (k < NS - 1) begin : g_mag
			always_ff @(posedge clk) begin
				if (en) begin
					nm[k+1] <= fits ? (nm[k] << SH) : nm[k];
				end
			end
		end
	end

	assign cst[0] = nst[NS];

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		aik_cordic_cell #(.IDX(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (cst[i]),
			.q   (cst[i+1])
		);
	end

	assign rounded = (cst[STAGES].acc + aik_pkg::ROUND_HALF) >>> aik_pkg::ROUND_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= cst[STAGES].zero ? '0 : aik_pkg::ANGW'(rounded);
		end
	end
endmodule

// ===== design/arm_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_core: two-link arm inverse kinematics with base yaw
// Target point in 1/256 cm to base, shoulder and elbow angles in 1/64 degree.
// ----------------------------------------------------------------------------
// The core takes one target point per clock while target.ready is high and
// returns one set of joint angles per point, in order, after eight front-end
// stages for the squares, reach clamp and law-of-cosines terms, 31 stages of
// the bit-per-stage square roots, then CORDIC_STAGES + 8 stages of the four
// parallel CORDIC arctangent units, and the output register. The whole
// pipeline moves together; target.ready falls only while the output register
// holds a beat that joint has not taken.
// Link lengths are written through cfg_we/cfg_index/cfg_data while no point
// is in flight.
module arm_inverse_kinematics_core #(
	parameter int CORDIC_STAGES = aik_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aik_pkg::CFG_W-1:0]     cfg_data,
	aik_target_if.sink                    target,
	aik_joint_if.source                   joint
);
	localparam int SQN = aik_pkg::SQ_STEPS;
	localparam int CORDIC_LAT = CORDIC_STAGES + aik_pkg::NORM_STEPS + 2;
	localparam int LAT = aik_pkg::FRONT_STAGES + SQN + CORDIC_LAT;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [31:0] num;
		logic signed [32:0] bx;
	} carry_t;

	logic [aik_pkg::CFG_W-1:0] l1_q;
	logic [aik_pkg::CFG_W-1:0] l2_q;
	logic                      en;
	logic [LAT-1:0]            vld_q;
	logic                      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= aik_pkg::UPPER_RESET;
			l2_q <= aik_pkg::LOWER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aik_pkg::REG_UPPER: l1_q <= cfg_data;
				aik_pkg::REG_LOWER: l2_q <= cfg_data;
			endcase
		end
	end

	assign en = !out_valid_q || joint.ready;
	assign target.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], target.valid};
		end
	end

	// Front end: squares, reach clamp and the law-of-cosines terms.
	logic signed [31:0] px, py, pz;
	logic signed [15:0] x_s1, y_s1, z_s1;
	logic [30:0]        x2_s1, y2_s1, z2_s1;
	logic [29:0]        l1sq_s1, l2sq_s1, l1l2_s1;
	logic [15:0]        reach_s1;

	assign px = target.target_x * target.target_x;
	assign py = target.target_y * target.target_y;
	assign pz = target.target_z * target.target_z;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= target.target_x;
			y_s1     <= target.target_y;
			z_s1     <= target.target_z;
			x2_s1    <= px[30:0];
			y2_s1    <= py[30:0];
			z2_s1    <= pz[30:0];
			l1sq_s1  <= 30'(l1_q) * 30'(l1_q);
			l2sq_s1  <= 30'(l2_q) * 30'(l2_q);
			l1l2_s1  <= 30'(l1_q) * 30'(l2_q);
			reach_s1 <= 16'(l1_q) + 16'(l2_q);
		end
	end

	logic signed [15:0] x_s2, y_s2, z_s2;
	logic [31:0]        planar_s2, reach2_s2;
	logic [30:0]        z2_s2, l12_s2, den_s2;
	logic [29:0]        l1sq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
			planar_s2 <= 32'(x2_s1) + 32'(y2_s1);
			reach2_s2 <= 32'(reach_s1) * 32'(reach_s1);
			z2_s2     <= z2_s1;
			l12_s2    <= 31'(l1sq_s1) + 31'(l2sq_s1);
			den_s2    <= {l1l2_s1, 1'b0};
			l1sq_s2   <= l1sq_s1;
		end
	end

	logic signed [15:0] x_s3, y_s3, z_s3;
	logic [31:0]        planar_s3, reach2_s3, d2_s3;
	logic [30:0]        l12_s3, den_s3;
	logic [29:0]        l1sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			z_s3      <= z_s2;
			planar_s3 <= planar_s2;
			reach2_s3 <= reach2_s2;
			d2_s3     <= planar_s2 + 32'(z2_s2);
			l12_s3    <= l12_s2;
			den_s3    <= den_s2;
			l1sq_s3   <= l1sq_s2;
		end
	end

	logic signed [15:0] x_s4, y_s4, z_s4;
	logic [31:0]        planar_s4, d2c_s4;
	logic [30:0]        l12_s4, den_s4;
	logic [29:0]        l1sq_s4;

	// Targets beyond full reach are pulled in to the reach circle.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s4      <= x_s3;
			y_s4      <= y_s3;
			z_s4      <= z_s3;
			planar_s4 <= planar_s3;
			d2c_s4    <= (d2_s3 > reach2_s3) ? reach2_s3 : d2_s3;
			l12_s4    <= l12_s3;
			den_s4    <= den_s3;
			l1sq_s4   <= l1sq_s3;
		end
	end

	logic signed [15:0] x_s5, y_s5, z_s5;
	logic [31:0]        planar_s5;
	logic signed [33:0] numr_s5;
	logic [30:0]        den_s5;
	logic [29:0]        l1sq_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5      <= x_s4;
			y_s5      <= y_s4;
			z_s5      <= z_s4;
			planar_s5 <= planar_s4;
			numr_s5   <= $signed({2'b00, d2c_s4}) - $signed({3'b000, l12_s4});
			den_s5    <= den_s4;
			l1sq_s5   <= l1sq_s4;
		end
	end

	logic signed [33:0] dens, numc;
	logic signed [15:0] x_s6, y_s6, z_s6;
	logic [31:0]        planar_s6;
	logic signed [31:0] num_s6;
	logic [30:0]        nabs_s6, den_s6;
	logic [29:0]        l1sq_s6;

	assign dens = $signed({3'b000, den_s5});
	assign numc = (numr_s5 > dens) ? dens : ((numr_s5 < -dens) ? -dens : numr_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6      <= x_s5;
			y_s6      <= y_s5;
			z_s6      <= z_s5;
			planar_s6 <= planar_s5;
			num_s6    <= 32'(numc);
			nabs_s6   <= 31'((numc < 0) ? -numc : numc);
			den_s6    <= den_s5;
			l1sq_s6   <= l1sq_s5;
		end
	end

	logic signed [15:0] x_s7, y_s7, z_s7;
	logic [31:0]        planar_s7;
	logic signed [31:0] num_s7;
	logic signed [32:0] bx_s7;
	logic [61:0]        den2_s7, num2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s7      <= x_s6;
			y_s7      <= y_s6;
			z_s7      <= z_s6;
			planar_s7 <= planar_s6;
			num_s7    <= num_s6;
			bx_s7     <= $signed({2'b00, l1sq_s6, 1'b0}) + 33'(num_s6);
			den2_s7   <= 62'(den_s6) * 62'(den_s6);
			num2_s7   <= 62'(nabs_s6) * 62'(nabs_s6);
		end
	end

	carry_t      c_s8;
	logic [31:0] planar_s8;
	logic [61:0] diff_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8.x    <= x_s7;
			c_s8.y    <= y_s7;
			c_s8.z    <= z_s7;
			c_s8.num  <= num_s7;
			c_s8.bx   <= bx_s7;
			planar_s8 <= planar_s7;
			diff_s8   <= den2_s7 - num2_s7;
		end
	end

	// Square roots: s for the elbow triangle, r as the planar distance.
	logic [aik_pkg::SQW/2-1:0] s_root, r_root;
	carry_t                    dly_q [SQN];
	carry_t                    cd;

	aik_sqrt u_sqrt_s (
		.clk      (clk),
		.en       (en),
		.radicand (diff_s8),
		.root     (s_root)
	);

	aik_sqrt u_sqrt_r (
		.clk      (clk),
		.en       (en),
		.radicand ({14'd0, planar_s8, 16'd0}),
		.root     (r_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= c_s8;
			for (int j = 1; j < SQN; j++) begin
				dly_q[j] <= dly_q[j-1];
			end
		end
	end

	assign cd = dly_q[SQN-1];

	aik_pkg::op_t  s_op, r_op;
	aik_pkg::ang_t base_ang, elbow_ang, alpha_ang, beta_ang;

	assign s_op = $signed({3'b000, s_root});
	assign r_op = $signed({3'b000, r_root});

	aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_base (
		.clk   (clk),
		.en    (en),
		.y_in  (aik_pkg::OPW'(cd.y)),
		.x_in  (aik_pkg::OPW'(cd.x)),
		.angle (base_ang)
	);

	aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_elbow (
		.clk   (clk),
		.en    (en),
		.y_in  (s_op),
		.x_in  (aik_pkg::OPW'(cd.num)),
		.angle (elbow_ang)
	);

	aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_alpha (
		.clk   (clk),
		.en    (en),
		.y_in  (aik_pkg::OPW'($signed({cd.z, 8'd0}))),
		.x_in  (r_op),
		.angle (alpha_ang)
	);

	aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_beta (
		.clk   (clk),
		.en    (en),
		.y_in  (s_op),
		.x_in  (aik_pkg::OPW'(cd.bx)),
		.angle (beta_ang)
	);

	// Output register with range saturation.
	aik_pkg::ang_t                base_c, elbow_c;
	logic signed [aik_pkg::ANGW:0] sh_d, sh_c;
	logic signed [14:0]           base_q;
	logic signed [15:0]           shoulder_q;
	logic [13:0]                  elbow_q;

	assign base_c = (base_ang > aik_pkg::BASE_MAX) ? aik_pkg::BASE_MAX :
		((base_ang < aik_pkg::BASE_MIN) ? aik_pkg::BASE_MIN : base_ang);
	assign elbow_c = (elbow_ang > aik_pkg::ELBOW_MAX) ? aik_pkg::ELBOW_MAX :
		((elbow_ang < 0) ? '0 : elbow_ang);
	assign sh_d = (aik_pkg::ANGW + 1)'(alpha_ang) - (aik_pkg::ANGW + 1)'(beta_ang);
	assign sh_c = (sh_d > aik_pkg::SH_MAX) ? aik_pkg::SH_MAX :
		((sh_d < aik_pkg::SH_MIN) ? aik_pkg::SH_MIN : sh_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_q     <= 15'(base_c);
			shoulder_q <= 16'(sh_c);
			elbow_q    <= 14'(elbow_c);
		end
	end

	assign joint.valid          = out_valid_q;
	assign joint.yaw_angle      = base_q;
	assign joint.shoulder_angle = shoulder_q;
	assign joint.elbow_angle    = elbow_q;

	// The input side stalls only behind a beat that is waiting at the output.
	ap_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!target.ready |-> (joint.valid && !joint.ready))
		else $error("input stalled without a waiting output beat");

	ap_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valids moved during a stall");

	ap_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[LAT-1]) |=> joint.valid)
		else $error("finished beat did not reach the output register");

	ap_shoulder_range: assert property (@(posedge clk) disable iff (!arst_n)
		joint.valid |-> (joint.shoulder_angle >= aik_pkg::SH_MIN &&
			joint.shoulder_angle <= aik_pkg::SH_MAX))
		else $error("shoulder angle outside its range");

endmodule

// ===== tb/arm_inverse_kinematics_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_core_test: self-checking bench of the IK core
// Streams target points under random source and sink stalls, predicts the
// joint angles with an independent fixed-point CORDIC model and checks every
// beat in order, across several link length settings.
// ----------------------------------------------------------------------------

class joint_scoreboard;
	typedef struct {
		logic [14:0] base;
		logic [15:0] shoulder;
		logic [13:0] elbow;
	} joint_t;

	longint l1 = aik_pkg::UPPER_RESET;
	longint l2 = aik_pkg::LOWER_RESET;
	joint_t pending_joints[$];
	int errors = 0;

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function longint vector_angle(longint y, longint x);
		longint acc = 0;
		longint t, dx, dy;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = aik_pkg::DEG90_FINE;
			end else begin
				x = -y; y = t; acc = -aik_pkg::DEG90_FINE;
			end
		end
		while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < aik_pkg::CORDIC_STAGES_DEF && i < aik_pkg::ATAN_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; acc += aik_pkg::ATAN_FINE[i];
			end else begin
				x -= dx; y += dy; acc -= aik_pkg::ATAN_FINE[i];
			end
		end
		return (acc + 32768) >>> 16;
	endfunction

	function longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function void set_link(logic idx, logic [14:0] val);
		if (idx == aik_pkg::REG_UPPER) l1 = val;
		else l2 = val;
	endfunction

	function void note_target(logic signed [15:0] tx, logic signed [15:0] ty,
		logic signed [15:0] tz);
		longint x = tx, y = ty, z = tz;
		longint planar2, d2, reach, den, num, s, r, base, elbow, alpha, beta, sh;
		joint_t j;
		planar2 = x * x + y * y;
		d2 = planar2 + z * z;
		reach = l1 + l2;
		den = 2 * l1 * l2;
		if (d2 > reach * reach) d2 = reach * reach;
		num = clip(d2 - l1 * l1 - l2 * l2, -den, den);
		s = int_sqrt(den * den - num * num);
		base = clip(vector_angle(y, x), -11520, 11520);
		elbow = clip(vector_angle(s, num), 0, 11520);
		r = int_sqrt(planar2 << 16);
		alpha = vector_angle(z * 256, r);
		beta = vector_angle(s, 2 * l1 * l1 + num);
		sh = clip(alpha - beta, -17280, 5760);
		j.base = base[14:0];
		j.shoulder = sh[15:0];
		j.elbow = elbow[13:0];
		pending_joints.push_back(j);
	endfunction

	function void check_joint(logic [14:0] b, logic [15:0] s, logic [13:0] e);
		joint_t j;
		if (pending_joints.size() == 0) begin
			$error("joint beat with no target outstanding");
			errors++;
			return;
		end
		j = pending_joints.pop_front();
		if (b !== j.base) begin
			$error("yaw_angle: expected %0d, actual %0d", $signed(j.base), $signed(b));
			errors++;
		end
		if (s !== j.shoulder) begin
			$error("shoulder_angle: expected %0d, actual %0d", $signed(j.shoulder),
				$signed(s));
			errors++;
		end
		if (e !== j.elbow) begin
			$error("elbow_angle: expected %0d, actual %0d", j.elbow, e);
			errors++;
		end
	endfunction
endclass

module arm_inverse_kinematics_core_test;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [aik_pkg::CFG_IDX_W-1:0] cfg_index = aik_pkg::REG_UPPER;
	logic [aik_pkg::CFG_W-1:0] cfg_data = '0;

	aik_target_if tgt ();
	aik_joint_if jnt ();

	joint_scoreboard sb = new();
	int src_idle = 0;
	int snk_idle = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	arm_inverse_kinematics_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .target(tgt.sink), .joint(jnt.source)
	);

	always #5 clk = ~clk;

	initial begin
		tgt.valid = 1'b0;
		tgt.target_x = '0;
		tgt.target_y = '0;
		tgt.target_z = '0;
		jnt.ready = 1'b0;
	end

	// Receiver side; a long hold-off is counted here once requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			jnt.ready = 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cycles = 300;
			jnt.ready = 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			jnt.ready = 1'b0;
		end else begin
			jnt.ready = ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (tgt.valid && tgt.ready) begin
				sb.note_target(tgt.target_x, tgt.target_y, tgt.target_z);
				quiet_cycles = 0;
			end
			if (jnt.valid && jnt.ready) begin
				sb.check_joint(jnt.yaw_angle, jnt.shoulder_angle, jnt.elbow_angle);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** arm_inverse_kinematics_core: FAILED **");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		while ($urandom_range(99) < src_idle) begin
			tgt.valid = 1'b0;
			@(negedge clk);
		end
		tgt.valid = 1'b1;
		tgt.target_x = x;
		tgt.target_y = y;
		tgt.target_z = z;
		@(posedge clk);
		while (!tgt.ready) @(posedge clk);
		@(negedge clk);
		tgt.valid = 1'b0;
	endtask

	task automatic write_link(logic [aik_pkg::CFG_IDX_W-1:0] idx,
		logic [aik_pkg::CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_link(idx, val);
	endtask

	task automatic drain();
		while (sb.pending_joints.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Each coordinate mostly within the arm's reach plus a margin, sometimes zero, some anywhere in the field range.
	task automatic send_random();
		longint span;
		logic signed [15:0] v [3];
		span = sb.l1 + sb.l2 + 64;
		if (span > 32767) span = 32767;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(9))
				0, 1, 2: v[k] = 16'($urandom);
				3: v[k] = '0;
				default: v[k] = 16'(longint'($urandom_range(32'(2 * span))) - span);
			endcase
		end
		send_target(v[0], v[1], v[2]);
	endtask

	task automatic send_directed();
		send_target(0, 0, 0);
		send_target(16'sh7fff, 0, 0);
		send_target(-16'sh8000, 0, 0);
		send_target(-100, 0, 50);
		send_target(0, 16'sh7fff, 0);
		send_target(0, -16'sh8000, 0);
		send_target(0, 0, 16'sh7fff);
		send_target(0, 0, -16'sh8000);
		send_target(-16'sh8000, -16'sh8000, -16'sh8000);
		send_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_target(-16'sh8000, 16'sh7fff, 0);
		send_target(-5, -1, 0);
		send_target(8960, 0, 0);
		send_target(0, 0, 8960);
		send_target(1280, 0, 0);
		send_target(0, 1280, 0);
		send_target(1, 1, 1);
		send_target(-1, -1, -1);
		send_target(3000, -4000, 2000);
		send_target(-6000, 2000, -3000);
		send_target(0, 0, 1);
		send_target(16'sh5555, -16'sh2aab, 16'sh2aaa);
	endtask

	initial begin
		logic [aik_pkg::CFG_W-1:0] uppers [7];
		logic [aik_pkg::CFG_W-1:0] lowers [7];
		uppers = '{aik_pkg::UPPER_RESET, 15'h7fff, 15'd1, 15'd1, 15'h7fff, 15'd0, 15'd0};
		lowers = '{aik_pkg::LOWER_RESET, 15'h7fff, 15'd1, 15'h7fff, 15'd1, 15'd2000,
			15'd0};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_directed();
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			if (ph == 6) begin
				uppers[ph] = 15'($urandom_range(32767));
				lowers[ph] = 15'($urandom_range(32767));
			end
			write_link(aik_pkg::REG_UPPER, uppers[ph]);
			write_link(aik_pkg::REG_LOWER, lowers[ph]);
			src_idle = (ph % 3 == 0) ? 26 : (ph % 3 == 1) ? 88 : 0;
			snk_idle = (ph % 3 == 0) ? 88 : (ph % 3 == 1) ? 26 : 0;
			if (ph == 2) send_directed();
			for (int n = 0; n < RANDOM_PER_PHASE - 20; n++) begin
				if (ph == 2 && n == 30) hold_req = 1'b1;
				send_random();
			end
		end
		drain();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending_joints.size() == 0) begin
			$display("** arm_inverse_kinematics_core: PASSED **");
		end else begin
			if (sb.pending_joints.size() != 0)
				$error("%0d joint beats never arrived", sb.pending_joints.size());
			$display("** arm_inverse_kinematics_core: FAILED **");
		end
		$finish;
	end

endmodule
